>>> hdl/vaphr_pkg.sv
// ----------------------------------------------------------------------------
// vaphr_pkg
// Shared types, register indexes and helpers for the audio packet header
// restore block.
// ----------------------------------------------------------------------------
package vaphr_pkg;

  // Configuration register indexes
  localparam logic REG_MODE_COUNT = 1'b0;
  localparam logic REG_MODE_LONG  = 1'b1;

  // Depth of the result queue
  localparam int OUTQ_DEPTH = 4;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic [5:0] mode_number;
    logic       long_block;
    logic       mode_error;
  } result_t;

  // Results produced by one input word: count, then up to two entries
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Number of bits needed to write v
  function automatic logic [2:0] bits_needed(input logic [5:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (v[i]) n = 3'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> hdl/vorbis_audio_packet_header_restore.sv
// ----------------------------------------------------------------------------
// vorbis_audio_packet_header_restore
// Rebuilds standard audio packets from stripped packets, one byte per word.
// Path: a byte accepted from the input stream is held in the input register,
// and its result words are written into the result queue before they reach
// the result stream. Throughput: one input word per cycle while the result
// queue has room; the last byte of a good packet yields two result words.
// Reset: synchronous, clears the input stage, queue and packet state, and
// sets mode_count to 1 and all long-block flags to 0.
// ----------------------------------------------------------------------------
module vorbis_audio_packet_header_restore #(
  parameter int MAX_MODES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  input  logic [1:0]  s_tuser,   // [0] previous_long, [1] next_long
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [13:8] mode_number,
                                 // [14] long_block, [15] zero
  output logic        m_tlast,   // end_of_packet
  output logic        m_tuser,   // mode_error
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic               in_valid;
  logic [7:0]         in_data;
  logic               in_last;
  logic               in_prev;
  logic               in_next;
  logic               fire;
  logic               room;
  logic [6:0]         mode_count;
  logic [63:0]        mode_long_flags;
  vaphr_pkg::push_t   push;
  vaphr_pkg::result_t out_item;

  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
      in_prev <= s_tuser[0];
      in_next <= s_tuser[1];
    end
  end

  vaphr_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode_count      (mode_count),
    .mode_long_flags (mode_long_flags)
  );

  vaphr_core #(
    .MAX_MODES (MAX_MODES)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .data_byte       (in_data),
    .last_byte       (in_last),
    .previous_long   (in_prev),
    .next_long       (in_next),
    .mode_count      (mode_count),
    .mode_long_flags (mode_long_flags),
    .push            (push)
  );

  vaphr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_en   (fire),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // Pack the result word
  assign m_tdata = {1'b0, out_item.long_block, out_item.mode_number, out_item.out_byte};
  assign m_tlast = out_item.end_of_packet;
  assign m_tuser = out_item.mode_error;

endmodule

>>> hdl/vaphr_core.sv
// ----------------------------------------------------------------------------
// vaphr_core
// Per-word restore logic: decodes the mode on a packet's first byte, inserts
// the header bits, shifts the payload and flushes the carry on the last byte.
// ----------------------------------------------------------------------------
module vaphr_core #(
  parameter int MAX_MODES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 previous_long,
  input  logic                 next_long,
  input  logic [6:0]           mode_count,
  input  logic [63:0]          mode_long_flags,
  output vaphr_pkg::push_t     push
);

  localparam logic [6:0] MaxCount = 7'(MAX_MODES);

  // Packet state
  logic [2:0] carry_bits,   carry_bits_next;
  logic [1:0] carry_count,  carry_count_next;
  logic       expect_first, expect_first_next;
  logic       drop_rest,    drop_rest_next;
  logic [5:0] held_mode,    held_mode_next;
  logic       held_long,    held_long_next;

  // First-byte decode
  logic [6:0]  count_clamped;
  logic [6:0]  count_m1;
  logic [2:0]  mode_bits;
  logic [7:0]  mode_mask;
  logic [7:0]  mode_raw;
  logic [5:0]  mode;
  logic        mode_bad;
  logic        mode_long;
  logic [3:0]  head_len;
  logic [10:0] head;
  logic [16:0] payload;
  logic [10:0] word;

  // Clamp the mode count and find the mode field width
  always_comb begin
    if (mode_count == 7'd0) begin
      count_clamped = 7'd1;
    end else if (mode_count > MaxCount) begin
      count_clamped = MaxCount;
    end else begin
      count_clamped = mode_count;
    end
    count_m1  = count_clamped - 7'd1;
    mode_bits = vaphr_pkg::bits_needed(count_m1[5:0]);
    mode_mask = 8'((9'd1 << mode_bits) - 9'd1);
    mode_raw  = data_byte & mode_mask;
    mode      = mode_raw[5:0];
    mode_bad  = {1'b0, mode} >= count_clamped;
    mode_long = mode_long_flags[mode];
  end

  // Build the output word and the next state
  always_comb begin
    carry_bits_next   = carry_bits;
    carry_count_next  = carry_count;
    expect_first_next = expect_first;
    drop_rest_next    = drop_rest;
    held_mode_next    = held_mode;
    held_long_next    = held_long;
    push              = '0;
    head_len          = 4'd1 + {1'b0, mode_bits};
    head              = {4'd0, mode, 1'b0};
    payload           = '0;
    word              = '0;

    if (drop_rest) begin
      // Discard the remainder of a bad packet
      if (last_byte) begin
        drop_rest_next    = 1'b0;
        expect_first_next = 1'b1;
      end
    end else if (expect_first && mode_bad) begin
      // Report the bad mode once and drop the rest
      push.count            = 2'd1;
      push.r0.end_of_packet = 1'b1;
      push.r0.mode_number   = mode;
      push.r0.mode_error    = 1'b1;
      drop_rest_next        = !last_byte;
      carry_bits_next       = 3'd0;
      carry_count_next      = 2'd0;
    end else begin
      if (expect_first) begin
        // Header: type bit, mode bits, optional window flags
        if (mode_long) begin
          head     = head | (11'(previous_long) << head_len)
                          | (11'(next_long) << (head_len + 4'd1));
          head_len = head_len + 4'd2;
        end
        payload           = ({9'd0, data_byte} >> mode_bits) << head_len;
        word              = head | payload[10:0];
        carry_count_next  = mode_long ? 2'd3 : 2'd1;
        held_mode_next    = mode;
        held_long_next    = mode_long;
        expect_first_next = 1'b0;
      end else begin
        word = {8'd0, carry_bits} | ({3'd0, data_byte} << carry_count);
      end
      carry_bits_next = word[10:8];

      push.count          = 2'd1;
      push.r0.out_byte    = word[7:0];
      push.r0.mode_number = held_mode_next;
      push.r0.long_block  = held_long_next;

      // Flush the carry as a final padded byte
      if (last_byte) begin
        push.count            = 2'd2;
        push.r1.out_byte      = {5'd0, word[10:8]};
        push.r1.end_of_packet = 1'b1;
        push.r1.mode_number   = held_mode_next;
        push.r1.long_block    = held_long_next;
        carry_bits_next       = 3'd0;
        carry_count_next      = 2'd0;
        expect_first_next     = 1'b1;
      end
    end
  end

  // Advance the packet state on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bits   <= 3'd0;
      carry_count  <= 2'd0;
      expect_first <= 1'b1;
      drop_rest    <= 1'b0;
      held_mode    <= 6'd0;
      held_long    <= 1'b0;
    end else if (fire) begin
      carry_bits   <= carry_bits_next;
      carry_count  <= carry_count_next;
      expect_first <= expect_first_next;
      drop_rest    <= drop_rest_next;
      held_mode    <= held_mode_next;
      held_long    <= held_long_next;
    end
  end

endmodule

>>> hdl/vaphr_outq.sv
// ----------------------------------------------------------------------------
// vaphr_outq
// Small result queue: takes up to two results per cycle while it has room
// and hands out one per cycle on the master stream side while out_ready is high.
// ----------------------------------------------------------------------------
module vaphr_outq (
  input  logic               clk,
  input  logic               rst,
  input  vaphr_pkg::push_t   push,
  input  logic               push_en,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output vaphr_pkg::result_t out_item
);

  localparam int Depth  = vaphr_pkg::OUTQ_DEPTH;
  localparam int PtrW   = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  vaphr_pkg::result_t mem [Depth];
  logic [PtrW-1:0]    wptr, rptr;
  logic [CountW-1:0]  count, count_next;
  logic [1:0]         push_n;
  logic               pop;

  assign push_n    = push_en ? push.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_item  = mem[rptr];
  // Keep space for a full two-result word
  assign room      = count <= CountW'(Depth - 2);

  assign count_next = count + CountW'(push_n) - CountW'(pop);

  // Write incoming results
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wptr] <= push.r0;
    if (push_n == 2'd2) mem[wptr + PtrW'(1)] <= push.r1;
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PtrW'(push_n);
      if (pop) rptr <= rptr + PtrW'(1);
      count <= count_next;
    end
  end

  // Occupancy never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Depth))
    else $error("result queue overfilled");

  // A push always finds space for all of its results
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ({1'b0, count} + (CountW + 1)'(push_n) <= (CountW + 1)'(Depth)))
    else $error("push exceeds free space");

  // Occupancy tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CountW'($past(push_n)) - CountW'($past(pop)))
    else $error("queue occupancy mismatch");

endmodule

>>> hdl/vaphr_regs.sv
// ----------------------------------------------------------------------------
// vaphr_regs
// Configuration registers: mode count and per-mode long-block flags.
// ----------------------------------------------------------------------------
module vaphr_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output logic [6:0]  mode_count,
  output logic [63:0] mode_long_flags
);

  assign cfg_ready = 1'b1;

  // Decode and store register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count      <= 7'd1;
      mode_long_flags <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vaphr_pkg::REG_MODE_COUNT: mode_count      <= cfg_data[6:0];
        vaphr_pkg::REG_MODE_LONG:  mode_long_flags <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> tb/tb_vorbis_audio_packet_header_restore.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vorbis_audio_packet_header_restore
// Drives stripped audio packets through the header restore block and checks
// every rebuilt word against an in-bench predictor of the bit splicing.
// Covers mode table sizes from one entry to the clamped maximum, long and
// short modes, out-of-table modes with the rest of the packet dropped,
// single-byte packets and register changes inside a packet. Both streams
// idle at random, and one long output hold fills the block up.
// ----------------------------------------------------------------------------
module tb_vorbis_audio_packet_header_restore;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  vorbis_audio_packet_header_restore uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and packet state
  logic [6:0]  mode_count_reg;
  logic [63:0] long_flags_reg;
  logic [2:0]  carry_bits;
  logic [1:0]  carry_count;
  bit          expect_first;
  bit          drop_rest;
  logic [5:0]  held_mode;
  bit          held_long;

  vaphr_pkg::result_t rebuilt_words[$];
  vaphr_pkg::result_t want_word;
  int          error_count;
  bit          tx_no_idle;
  bit          rx_no_idle;
  int          rx_hold;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Count one mismatch and print it if it is among the first 40
  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 40)
      $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Number of bits needed to write v
  function automatic int unsigned bit_width(input int unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  // Random idle length: mostly none or short, a few long
  function automatic int pick_gap(input bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Packet length: mostly short, sometimes longer
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  // Work out the rebuilt words caused by one accepted input word
  task automatic restore_predict(input logic [7:0] data, input bit last,
                                 input bit prev, input bit next);
    int unsigned d, count, mb, mode, hlen, head, word, total;
    vaphr_pkg::result_t r;
    d = data;
    if (drop_rest) begin
      if (last) begin
        drop_rest = 1'b0;
        expect_first = 1'b1;
      end
      return;
    end
    if (expect_first) begin
      count = mode_count_reg;
      if (count < 1) count = 1;
      if (count > 64) count = 64;
      mb = bit_width(count - 1);
      mode = d & ((1 << mb) - 1);
      if (mode >= count) begin
        // Out-of-table mode: one error word, drop the rest of the packet
        r.out_byte      = 8'h00;
        r.end_of_packet = 1'b1;
        r.mode_number   = 6'(mode);
        r.long_block    = 1'b0;
        r.mode_error    = 1'b1;
        rebuilt_words = {rebuilt_words, r};
        expect_first = 1'b1;
        drop_rest = !last;
        carry_bits = '0;
        carry_count = '0;
        return;
      end
      held_mode = 6'(mode);
      held_long = long_flags_reg[mode];
      head = mode << 1;
      hlen = 1 + mb;
      if (held_long) begin
        head = head | (int'(prev) << hlen) | (int'(next) << (hlen + 1));
        hlen = hlen + 2;
      end
      word = head | ((d >> mb) << hlen);
      total = hlen + 8 - mb;
      expect_first = 1'b0;
    end else begin
      word = int'(carry_bits) | (d << carry_count);
      total = carry_count + 8;
    end
    carry_count = 2'((total - 8) & 3);
    carry_bits = 3'((word >> 8) & 7);
    r.out_byte      = 8'(word);
    r.end_of_packet = 1'b0;
    r.mode_number   = held_mode;
    r.long_block    = held_long;
    r.mode_error    = 1'b0;
    rebuilt_words = {rebuilt_words, r};
    if (last) begin
      // Flush the carry as one zero-padded word
      r.out_byte      = {5'b0, carry_bits};
      r.end_of_packet = 1'b1;
      rebuilt_words = {rebuilt_words, r};
      carry_bits = '0;
      carry_count = '0;
      expect_first = 1'b1;
    end
  endtask

  // Offer one input word after a random gap and hold it until accepted
  task automatic send_word(input logic [7:0] data, input bit last, input logic [1:0] user);
    int gap;
    gap = pick_gap(tx_no_idle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    s_tuser  <= user;
    do @(posedge clk); while (!s_tready);
    restore_predict(data, last, user[0], user[1]);
  endtask

  task automatic send_idle();
    s_tvalid <= 1'b0;
  endtask

  // Send a whole packet with a chosen first byte
  task automatic send_packet(input int len, input logic [7:0] first);
    for (int i = 0; i < len; i++)
      send_word((i == 0) ? first : 8'($urandom), i == len - 1, 2'($urandom));
  endtask

  // Wait until every expected word has arrived, plus the pipeline latency
  task automatic wait_drained();
    send_idle();
    while (rebuilt_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; cfg_valid stays high for a following write
  task automatic cfg_write(input logic index, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == vaphr_pkg::REG_MODE_COUNT) mode_count_reg = value[6:0];
    else long_flags_reg = value;
  endtask

  // Drain, then write both registers
  task automatic set_config(input logic [6:0] count, input logic [63:0] flags);
    logic [63:0] count_word;
    wait_drained();
    count_word = {$urandom, $urandom};
    if ($urandom_range(0, 1)) count_word = '0;
    count_word[6:0] = count;
    cfg_write(vaphr_pkg::REG_MODE_COUNT, count_word);
    cfg_write(vaphr_pkg::REG_MODE_LONG, flags);
    cfg_valid <= 1'b0;
  endtask

  // Reset values: one mode, all short
  task automatic test_reset_defaults();
    send_packet(1, 8'h00);
    send_packet(1, 8'hFF);
    send_packet(3, 8'h5A);
  endtask

  // Table sizes, long flags, window bits and out-of-table modes
  task automatic test_modes_and_flags();
    set_config(7'd64, '1);
    send_word(8'hFF, 1'b1, 2'b11);
    send_word(8'h00, 1'b1, 2'b01);
    set_config(7'd5, 64'h5);
    send_word(8'hF5, 1'b1, 2'b00);
    send_packet(3, 8'h07);
    send_word(8'h02, 1'b1, 2'b10);
    send_word(8'hFC, 1'b1, 2'b11);
    set_config(7'd0, '1);
    send_word(8'hA5, 1'b1, 2'b11);
    set_config(7'd127, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(8'h81, 1'b1, 2'b01);
  endtask

  // Registers rewritten between bytes of one packet
  task automatic test_config_mid_packet();
    set_config(7'd2, 64'h1);
    send_word(8'h00, 1'b0, 2'b11);
    set_config(7'd64, 64'h0);
    send_word(8'hC3, 1'b0, 2'b00);
    send_word(8'h3C, 1'b1, 2'b00);
  endtask

  // Random packets over a series of random settings
  task automatic test_random_packets();
    int sent, len, r;
    logic [6:0]  count;
    logic [63:0] flags;
    for (int phase = 0; phase < 18; phase++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: count = 7'd0;
        1: count = 7'd1;
        2: count = 7'd64;
        3: count = 7'd127;
        4: count = 7'd2;
        default: count = 7'($urandom_range(0, 127));
      endcase
      r = $urandom_range(0, 5);
      if (r == 0) flags = '0;
      else if (r == 1) flags = '1;
      else flags = {$urandom, $urandom};
      set_config(count, flags);
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 95) begin
        len = pick_length();
        send_packet(len, 8'($urandom));
        sent += len;
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Hold the output off for a long stretch while input keeps coming
  task automatic test_output_hold();
    set_config(7'd64, {$urandom, $urandom});
    rx_hold = 300;
    tx_no_idle = 1'b1;
    for (int i = 0; i < 12; i++) send_packet($urandom_range(2, 6), 8'($urandom));
    tx_no_idle = 1'b0;
  endtask

  // Pause the sender until every word is out, then resume
  task automatic test_sender_pause();
    for (int i = 0; i < 5; i++) send_packet($urandom_range(1, 5), 8'($urandom));
    wait_drained();
    for (int i = 0; i < 5; i++) send_packet($urandom_range(1, 5), 8'($urandom));
  endtask

  // Receiver: random stalls, plus a long hold on request
  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = pick_gap(rx_no_idle);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (rebuilt_words.size() == 0) begin
        report_mismatch("unexpected word", {m_tuser, m_tlast, m_tdata}, 0);
      end else begin
        want_word = rebuilt_words.pop_front();
        if (m_tdata[7:0] != want_word.out_byte)
          report_mismatch("out_byte", m_tdata[7:0], want_word.out_byte);
        if (m_tlast != want_word.end_of_packet)
          report_mismatch("end_of_packet", m_tlast, want_word.end_of_packet);
        if (m_tdata[13:8] != want_word.mode_number)
          report_mismatch("mode_number", m_tdata[13:8], want_word.mode_number);
        if (m_tdata[14] != want_word.long_block)
          report_mismatch("long_block", m_tdata[14], want_word.long_block);
        if (m_tuser != want_word.mode_error)
          report_mismatch("mode_error", m_tuser, want_word.mode_error);
        if (m_tdata[15] != 1'b0)
          report_mismatch("pad bit", m_tdata[15], 0);
      end
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = vaphr_pkg::REG_MODE_COUNT;
    cfg_data = '0;
    mode_count_reg = 7'd1;
    long_flags_reg = '0;
    carry_bits = '0;
    carry_count = '0;
    expect_first = 1'b1;
    drop_rest = 1'b0;
    held_mode = '0;
    held_long = 1'b0;
    error_count = 0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    rx_hold = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_modes_and_flags();
    test_config_mid_packet();
    test_random_packets();
    test_output_hold();
    test_sender_pause();

    wait_drained();
    repeat (6) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/vaphr_pkg.sv
hdl/vaphr_core.sv
hdl/vaphr_outq.sv
hdl/vaphr_regs.sv
hdl/vorbis_audio_packet_header_restore.sv
tb/tb_vorbis_audio_packet_header_restore.sv
